// ===== src/box_bound_stationarity_audit_unit_macros.svh =====
// Assertion macros shared by the stationarity audit checkers.
`ifndef BOX_BOUND_STATIONARITY_AUDIT_UNIT_MACROS_SVH
`define BOX_BOUND_STATIONARITY_AUDIT_UNIT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define BBSA_ASSERT_SAME(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("bbsa same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define BBSA_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("bbsa next-cycle check failed");

`endif

// ===== src/bbsa_pkg.sv =====
// Shared types and constants of the stationarity audit unit.
`default_nettype none

package bbsa_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_RESET_TOL = 0;
  localparam int CFG_RESET_DEFAULT = 66;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOUND_TOL  = 3'd0,
    CFG_CONS_REL   = 3'd1,
    CFG_REL_MODE   = 3'd2,
    CFG_ABS_THR    = 3'd3,
    CFG_REL_THR    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ACT_INTERIOR = 2'd0,
    ACT_LOWER    = 2'd1,
    ACT_UPPER    = 2'd2
  } act_code_e;

  typedef enum logic [1:0] {
    MUL_SCALE = 2'd0,
    MUL_THR   = 2'd1,
    MUL_CONS  = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     classify;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_en;
    logic     thr_load;
    logic     cons_load;
    logic     div_start;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_busy;
  } status_t;

endpackage

`default_nettype wire

// ===== src/bbsa_if.sv =====
// Word channels of the stationarity audit unit: coordinate input and result output.
`default_nettype none

interface bbsa_in_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] coord_value;
  logic [DATA_WIDTH-1:0] coord_gradient;
  logic                  gradient_finite;
  logic [DATA_WIDTH-1:0] lower_bound;
  logic                  lower_finite;
  logic [DATA_WIDTH-1:0] upper_bound;
  logic                  upper_finite;
  logic                  last_coord;
  logic [DATA_WIDTH-1:0] objective_value;
  logic                  objective_finite;
  logic [DATA_WIDTH-1:0] reported_value;
  logic                  reported_finite;

  modport source (
    output valid, coord_value, coord_gradient, gradient_finite, lower_bound,
           lower_finite, upper_bound, upper_finite, last_coord, objective_value,
           objective_finite, reported_value, reported_finite,
    input  ready
  );

  modport sink (
    input  valid, coord_value, coord_gradient, gradient_finite, lower_bound,
           lower_finite, upper_bound, upper_finite, last_coord, objective_value,
           objective_finite, reported_value, reported_finite,
    output ready
  );
endinterface

interface bbsa_out_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            active_code;
  logic                  final_flag;
  logic [DATA_WIDTH-2:0] projected_norm;
  logic [DATA_WIDTH-2:0] raw_norm;
  logic                  raw_norm_valid;
  logic [DATA_WIDTH-2:0] scaled_norm;
  logic [DATA_WIDTH-2:0] threshold_used;
  logic                  is_stationary;
  logic                  is_consistent;
  logic                  objective_ok;

  modport source (
    output valid, active_code, final_flag, projected_norm, raw_norm, raw_norm_valid,
           scaled_norm, threshold_used, is_stationary, is_consistent, objective_ok,
    input  ready
  );

  modport sink (
    input  valid, active_code, final_flag, projected_norm, raw_norm, raw_norm_valid,
           scaled_norm, threshold_used, is_stationary, is_consistent, objective_ok,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/box_bound_stationarity_audit_unit.sv =====
// Top level of the box-bound projected-gradient stationarity audit unit.
//
// Coordinates arrive one word at a time on in_ch and each one produces one
// result word on out_ch. A coordinate is tested against its finite bounds
// (within bound_tolerance), an outward gradient at an active bound is zeroed,
// and running maxima of the projected gradient, of the projected gradient
// times max(|x|,1) and of the raw gradient are kept. The word flagged
// last_coord closes the point: its result carries the summary (norms, the
// scaled norm over max(|f|,1), threshold, stationary and consistency verdicts)
// and the running maxima restart for the next point. The last coordinate also
// runs the restoring divider, which yields one quotient bit per cycle. One
// word is in flight at a time; results sit in an output register, so a new
// coordinate is taken while the previous result waits, and the block holds
// only when a second result is ready before the first one is taken.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the
// next clock edge; issue them only while no word is in flight.
`default_nettype none

module box_bound_stationarity_audit_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bbsa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_WIDTH-2:0]          cfg_data_i,
  bbsa_in_if.sink                        in_ch,
  bbsa_out_if.source                     out_ch
);
  import bbsa_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    out_valid;

  // sequencer: handshakes and step commands
  bbsa_ctrl u_bbsa_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ready),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: config registers, bound test, multiplier, maxima, divider, result register
  bbsa_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_bbsa_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .coord_value_i      (in_ch.coord_value),
    .coord_gradient_i   (in_ch.coord_gradient),
    .gradient_finite_i  (in_ch.gradient_finite),
    .lower_bound_i      (in_ch.lower_bound),
    .lower_finite_i     (in_ch.lower_finite),
    .upper_bound_i      (in_ch.upper_bound),
    .upper_finite_i     (in_ch.upper_finite),
    .last_coord_i       (in_ch.last_coord),
    .objective_value_i  (in_ch.objective_value),
    .objective_finite_i (in_ch.objective_finite),
    .reported_value_i   (in_ch.reported_value),
    .reported_finite_i  (in_ch.reported_finite),
    .active_code_o      (out_ch.active_code),
    .final_flag_o       (out_ch.final_flag),
    .projected_norm_o   (out_ch.projected_norm),
    .raw_norm_o         (out_ch.raw_norm),
    .raw_norm_valid_o   (out_ch.raw_norm_valid),
    .scaled_norm_o      (out_ch.scaled_norm),
    .threshold_used_o   (out_ch.threshold_used),
    .is_stationary_o    (out_ch.is_stationary),
    .is_consistent_o    (out_ch.is_consistent),
    .objective_ok_o     (out_ch.objective_ok)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

// ===== src/bbsa_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module bbsa_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [DATA_WIDTH+FRAC_BITS-2:0] num_i,
  input  logic [DATA_WIDTH-1:0]           den_i,
  output logic                            busy_o,
  output logic [DATA_WIDTH+FRAC_BITS-2:0] quot_o
);

  localparam int NumW = DATA_WIDTH + FRAC_BITS - 1;
  localparam int CntW = $clog2(NumW);

  logic [NumW-1:0]       quot_q;
  logic [DATA_WIDTH-1:0] rem_q;
  logic [DATA_WIDTH-1:0] den_q;
  logic [CntW-1:0]       cnt_q;
  logic                  busy_q;
  logic [DATA_WIDTH:0]   trial;
  logic                  fits;

  assign trial = {rem_q, quot_q[NumW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(NumW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when the divisor fits
      if (fits) begin
        rem_q <= DATA_WIDTH'(trial - {1'b0, den_q});
      end else begin
        rem_q <= trial[DATA_WIDTH-1:0];
      end
      quot_q <= {quot_q[NumW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== src/bbsa_dp.sv =====
// Datapath of the stationarity audit: registers, bound test, shared multiplier, maxima, divider.
`default_nettype none

module bbsa_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bbsa_pkg::cmd_t                      cmd_i,
  output bbsa_pkg::status_t                   status_o,
  input  logic                                cfg_we_i,
  input  logic [bbsa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [DATA_WIDTH-2:0]               cfg_data_i,
  input  logic [DATA_WIDTH-1:0]               coord_value_i,
  input  logic [DATA_WIDTH-1:0]               coord_gradient_i,
  input  logic                                gradient_finite_i,
  input  logic [DATA_WIDTH-1:0]               lower_bound_i,
  input  logic                                lower_finite_i,
  input  logic [DATA_WIDTH-1:0]               upper_bound_i,
  input  logic                                upper_finite_i,
  input  logic                                last_coord_i,
  input  logic [DATA_WIDTH-1:0]               objective_value_i,
  input  logic                                objective_finite_i,
  input  logic [DATA_WIDTH-1:0]               reported_value_i,
  input  logic                                reported_finite_i,
  output logic [1:0]                          active_code_o,
  output logic                                final_flag_o,
  output logic [DATA_WIDTH-2:0]               projected_norm_o,
  output logic [DATA_WIDTH-2:0]               raw_norm_o,
  output logic                                raw_norm_valid_o,
  output logic [DATA_WIDTH-2:0]               scaled_norm_o,
  output logic [DATA_WIDTH-2:0]               threshold_used_o,
  output logic                                is_stationary_o,
  output logic                                is_consistent_o,
  output logic                                objective_ok_o
);
  import bbsa_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int PW   = 2 * DW;
  localparam int NumW = DW + FRAC_BITS - 1;
  localparam logic [DW-1:0] OneQ = {{(DW-1-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [DW-2:0] MaxQ = {(DW-1){1'b1}};

  function automatic logic [DW-1:0] mag_f(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [DW-2:0] sat_f(input logic [DW-1:0] u);
    return u[DW-1] ? MaxQ : u[DW-2:0];
  endfunction

  function automatic logic [DW-2:0] psat_f(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = p >> FRAC_BITS;
    return (|s[PW-1:DW-1]) ? MaxQ : s[DW-2:0];
  endfunction

  // configuration
  logic [DW-2:0] tol_q, cons_rel_q, abs_thr_q, rel_thr_q;
  logic          rel_mode_q;

  // captured word
  logic [DW-1:0] x_q, g_q, lo_q, up_q, f_q, rep_q;
  logic          gfin_q, lofin_q, upfin_q, last_q, ffin_q, repfin_q;

  // classified operands
  act_code_e     code_q;
  logic [DW-2:0] ag_q, rg_q;
  logic [DW-1:0] sx_q, den_q;
  logic [DW:0]   opf_q, oprep_q, frdiff_q;

  // running state
  logic [DW-2:0] proj_max_q, scaled_max_q, raw_max_q;
  logic          all_fin_q;

  logic [PW-1:0] prod_q;
  logic [DW-2:0] thr_q;
  logic          cons_ok_q;

  // combinational classification
  logic signed [DW:0] lo_gap, up_gap, tol_s, fr_gap;
  logic               at_lo, at_up, zeroed, g_pos;
  logic [DW-1:0]      mag_g, mag_x, mag_f_val, mag_rep;
  logic [DW-2:0]      ag_d, sc_val;
  act_code_e          code_d;
  logic [DW-2:0]      mul_a;
  logic [DW:0]        mul_b;
  logic [NumW-1:0]    quot;
  logic               div_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q      <= (DW-1)'(CFG_RESET_TOL);
      cons_rel_q <= (DW-1)'(CFG_RESET_DEFAULT);
      rel_mode_q <= 1'b0;
      abs_thr_q  <= (DW-1)'(CFG_RESET_DEFAULT);
      rel_thr_q  <= (DW-1)'(CFG_RESET_DEFAULT);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_BOUND_TOL: tol_q      <= cfg_data_i;
        CFG_CONS_REL:  cons_rel_q <= cfg_data_i;
        CFG_REL_MODE:  rel_mode_q <= cfg_data_i[0];
        CFG_ABS_THR:   abs_thr_q  <= cfg_data_i;
        CFG_REL_THR:   rel_thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q      <= coord_value_i;
      g_q      <= coord_gradient_i;
      gfin_q   <= gradient_finite_i;
      lo_q     <= lower_bound_i;
      lofin_q  <= lower_finite_i;
      up_q     <= upper_bound_i;
      upfin_q  <= upper_finite_i;
      last_q   <= last_coord_i;
      f_q      <= objective_value_i;
      ffin_q   <= objective_finite_i;
      rep_q    <= reported_value_i;
      repfin_q <= reported_finite_i;
    end
  end

  always_comb begin
    lo_gap    = $signed({x_q[DW-1], x_q}) - $signed({lo_q[DW-1], lo_q});
    up_gap    = $signed({up_q[DW-1], up_q}) - $signed({x_q[DW-1], x_q});
    tol_s     = $signed({2'b00, tol_q});
    at_lo     = lofin_q && (lo_gap <= tol_s);
    at_up     = upfin_q && (up_gap <= tol_s);
    g_pos     = !g_q[DW-1] && (|g_q);
    zeroed    = (at_lo && g_pos) || (at_up && g_q[DW-1]);
    mag_g     = mag_f(g_q);
    mag_x     = mag_f(x_q);
    mag_f_val = mag_f(f_q);
    mag_rep   = mag_f(rep_q);
    fr_gap    = $signed({f_q[DW-1], f_q}) - $signed({rep_q[DW-1], rep_q});
    if (zeroed) begin
      ag_d = '0;
    end else if (!gfin_q) begin
      ag_d = MaxQ;
    end else begin
      ag_d = sat_f(mag_g);
    end
    if (at_up) begin
      code_d = ACT_UPPER;
    end else if (at_lo) begin
      code_d = ACT_LOWER;
    end else begin
      code_d = ACT_INTERIOR;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.classify) begin
      code_q   <= code_d;
      ag_q     <= ag_d;
      rg_q     <= sat_f(mag_g);
      sx_q     <= (mag_x < OneQ) ? OneQ : mag_x;
      den_q    <= (mag_f_val < OneQ) ? OneQ : mag_f_val;
      opf_q    <= {1'b0, OneQ} + {1'b0, mag_f_val};
      oprep_q  <= {1'b0, OneQ} + {1'b0, mag_rep};
      frdiff_q <= fr_gap[DW] ? (~fr_gap + 1'b1) : fr_gap;
    end
  end

  // shared multiplier, one operand pair per cycle while mul_en is set
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_SCALE: begin
        mul_a = ag_q;
        mul_b = {1'b0, sx_q};
      end
      MUL_THR: begin
        mul_a = rel_thr_q;
        mul_b = opf_q;
      end
      MUL_CONS: begin
        mul_a = cons_rel_q;
        mul_b = oprep_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= {{(DW+1){1'b0}}, mul_a} * {{(DW-1){1'b0}}, mul_b};
    end
  end

  assign sc_val = psat_f(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proj_max_q   <= '0;
      scaled_max_q <= '0;
      raw_max_q    <= '0;
      all_fin_q    <= 1'b1;
    end else if (cmd_i.acc_en) begin
      if (ag_q > proj_max_q) begin
        proj_max_q <= ag_q;
      end
      if (sc_val > scaled_max_q) begin
        scaled_max_q <= sc_val;
      end
      if (gfin_q) begin
        if (rg_q > raw_max_q) begin
          raw_max_q <= rg_q;
        end
      end else begin
        all_fin_q <= 1'b0;
      end
    end else if (cmd_i.out_load && last_q) begin
      // drop the running state for the next point
      proj_max_q   <= '0;
      scaled_max_q <= '0;
      raw_max_q    <= '0;
      all_fin_q    <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.thr_load) begin
      thr_q <= rel_mode_q ? sc_val : abs_thr_q;
    end
    if (cmd_i.cons_load) begin
      cons_ok_q <= {{(DW-1){1'b0}}, frdiff_q} <= (prod_q >> FRAC_BITS);
    end
  end

  bbsa_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_bbsa_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   ({scaled_max_q, {FRAC_BITS{1'b0}}}),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      active_code_o    <= code_q;
      final_flag_o     <= last_q;
      projected_norm_o <= '0;
      raw_norm_o       <= '0;
      raw_norm_valid_o <= 1'b0;
      scaled_norm_o    <= '0;
      threshold_used_o <= '0;
      is_stationary_o  <= 1'b0;
      is_consistent_o  <= 1'b0;
      objective_ok_o   <= 1'b0;
      if (last_q) begin
        projected_norm_o <= proj_max_q;
        raw_norm_o       <= all_fin_q ? raw_max_q : '0;
        raw_norm_valid_o <= all_fin_q;
        objective_ok_o   <= ffin_q;
        if (ffin_q) begin
          scaled_norm_o    <= quot[DW-2:0];
          threshold_used_o <= thr_q;
          is_stationary_o  <= proj_max_q <= thr_q;
          is_consistent_o  <= repfin_q && cons_ok_q;
        end
      end
    end
  end

  assign status_o.last     = last_q;
  assign status_o.div_busy = div_busy;

endmodule

`default_nettype wire

// ===== src/bbsa_ctrl.sv =====
// Sequencer of the stationarity audit: steps one word through the datapath.
`default_nettype none

module bbsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  bbsa_pkg::status_t status_i,
  output bbsa_pkg::cmd_t    cmd_o
);
  import bbsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_MUL,
    S_ACC,
    S_THR,
    S_CONS,
    S_CHK,
    S_DIV,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  cmd_t   cmd;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_SCALE;
    unique case (state_q)
      S_IDLE:  cmd.load_in = in_valid_i;
      S_CLASS: cmd.classify = 1'b1;
      S_MUL:   cmd.mul_en = 1'b1;
      S_ACC:   cmd.acc_en = 1'b1;
      S_THR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_THR;
      end
      S_CONS: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_CONS;
        cmd.thr_load = 1'b1;
      end
      S_CHK: begin
        cmd.cons_load = 1'b1;
        cmd.div_start = 1'b1;
      end
      S_DIV: ;
      S_EMIT:  cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_CLASS;
        S_CLASS: state_q <= S_MUL;
        S_MUL:   state_q <= S_ACC;
        S_ACC:   state_q <= status_i.last ? S_THR : S_EMIT;
        S_THR:   state_q <= S_CONS;
        S_CONS:  state_q <= S_CHK;
        S_CHK:   state_q <= S_DIV;
        S_DIV:   if (!status_i.div_busy) state_q <= S_EMIT;
        S_EMIT:  if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

// ===== src/bbsa_chk.sv =====
// Port-level checker of the stationarity audit unit and its bind.
`default_nettype none

`include "box_bound_stationarity_audit_unit_macros.svh"

module bbsa_chk #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  final_flag_i,
  input logic [DATA_WIDTH-2:0] projected_norm_i,
  input logic [DATA_WIDTH-2:0] raw_norm_i,
  input logic                  raw_norm_valid_i,
  input logic [DATA_WIDTH-2:0] scaled_norm_i,
  input logic [DATA_WIDTH-2:0] threshold_used_i,
  input logic                  is_stationary_i,
  input logic                  is_consistent_i,
  input logic                  objective_ok_i
);

  logic verdicts_zero;
  logic summary_zero;

  assign verdicts_zero = scaled_norm_i == '0 && threshold_used_i == '0 &&
                         !is_stationary_i && !is_consistent_i;
  assign summary_zero  = verdicts_zero && projected_norm_i == '0 && raw_norm_i == '0 &&
                         !raw_norm_valid_i && !objective_ok_i;

  // hold a result until it is taken
  `BBSA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // one word in flight: no acceptance right after one
  `BBSA_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // summary fields are zero on a non-final result
  `BBSA_ASSERT_SAME(a_nonfinal_zero, clk_i, rst_ni, out_valid_i && !final_flag_i, summary_zero)

  // raw norm reads zero once a gradient was not finite
  `BBSA_ASSERT_SAME(a_raw_invalid_zero, clk_i, rst_ni, out_valid_i && !raw_norm_valid_i, raw_norm_i == '0)

  // a non-finite objective clears every verdict
  `BBSA_ASSERT_SAME(a_obj_bad_clear, clk_i, rst_ni, out_valid_i && !objective_ok_i, verdicts_zero)

endmodule

bind box_bound_stationarity_audit_unit bbsa_chk #(
  .DATA_WIDTH (DATA_WIDTH)
) u_bbsa_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_ch.valid),
  .in_ready_i       (in_ch.ready),
  .out_valid_i      (out_ch.valid),
  .out_ready_i      (out_ch.ready),
  .final_flag_i     (out_ch.final_flag),
  .projected_norm_i (out_ch.projected_norm),
  .raw_norm_i       (out_ch.raw_norm),
  .raw_norm_valid_i (out_ch.raw_norm_valid),
  .scaled_norm_i    (out_ch.scaled_norm),
  .threshold_used_i (out_ch.threshold_used),
  .is_stationary_i  (out_ch.is_stationary),
  .is_consistent_i  (out_ch.is_consistent),
  .objective_ok_i   (out_ch.objective_ok)
);

`default_nettype wire

// ===== sim/box_bound_stationarity_audit_unit_tb.sv =====
// Self-checking bench for the stationarity audit unit: probe table, then random points.
`timescale 1ns / 100ps

module box_bound_stationarity_audit_unit_tb;
  import bbsa_pkg::*;

  typedef longint unsigned u64_t;

  // One coordinate word as it enters the block.
  typedef struct packed {
    logic signed [31:0] coord_value;
    logic signed [31:0] coord_gradient;
    logic               gradient_finite;
    logic signed [31:0] lower_bound;
    logic               lower_finite;
    logic signed [31:0] upper_bound;
    logic               upper_finite;
    logic               last_coord;
    logic signed [31:0] objective_value;
    logic               objective_finite;
    logic signed [31:0] reported_value;
    logic               reported_finite;
  } coord_t;

  // One result word as it leaves the block.
  typedef struct packed {
    act_code_e   active_code;
    logic        final_flag;
    logic [30:0] projected_norm;
    logic [30:0] raw_norm;
    logic        raw_norm_valid;
    logic [30:0] scaled_norm;
    logic [30:0] threshold_used;
    logic        is_stationary;
    logic        is_consistent;
    logic        objective_ok;
  } result_t;

  // Probe row: stimulus plus, where obvious, the result typed in by hand.
  typedef struct {
    coord_t  stim;
    bit      typed;
    result_t want;
  } probe_row_t;

  localparam int          FRAC       = 16;
  localparam u64_t        Q_UNIT     = 64'h0001_0000;
  localparam u64_t        Q_SAT      = 64'h7FFF_FFFF;
  localparam logic [31:0] Q_ONE      = 32'h0001_0000;
  localparam logic [31:0] Q_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN      = 32'h8000_0000;
  localparam logic [30:0] Q31_MAX    = 31'h7FFF_FFFF;
  localparam int          PHASES     = 8;
  localparam int          PHASE_LEN  = 230;
  localparam int          DRAIN_WAIT = 60;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_we;
  cfg_reg_e  cfg_idx;
  logic [30:0] cfg_data;

  bbsa_in_if  #(.DATA_WIDTH(32)) coord_ch ();
  bbsa_out_if #(.DATA_WIDTH(32)) result_ch ();

  box_bound_stationarity_audit_unit #(
    .DATA_WIDTH(32),
    .FRAC_BITS (16)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_ch     (coord_ch),
    .out_ch    (result_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the configuration registers.
  u64_t tol_q, cons_rel_q, abs_thr_q, rel_thr_q;
  bit   rel_mode_q;

  // Running state of the point being audited.
  u64_t pg_peak, scaled_peak, raw_peak;
  bit   grad_all_finite;

  result_t    results_due[$];
  probe_row_t probe_tab[$];
  int         fail_count   = 0;
  int         idle_pct     = 22;
  bit         out_hold_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Fixed-point helpers and the audit predictor
  // ---------------------------------------------------------------------------

  function automatic u64_t magnitude(input longint v);
    return (v < 0) ? u64_t'(-v) : u64_t'(v);
  endfunction

  function automatic u64_t clip(input u64_t u);
    return (u > Q_SAT) ? Q_SAT : u;
  endfunction

  // Truncating Q16.16 product of nonnegative operands, saturated.
  function automatic u64_t q_mul(input u64_t a, input u64_t b);
    return clip((a * b) >> FRAC);
  endfunction

  // Classify one coordinate, fold it into the running maxima, and on the
  // closing coordinate build the summary and restart the point.
  function automatic result_t audit_coord(input coord_t c);
    longint  x, g, lo, up, f, rep;
    bit      at_lo, at_up, zeroed;
    u64_t    pg, xs, sg, obj_mag, den, thr, allow;
    result_t r;
    x   = c.coord_value;
    g   = c.coord_gradient;
    lo  = c.lower_bound;
    up  = c.upper_bound;
    f   = c.objective_value;
    rep = c.reported_value;
    // Differences are taken at full width, so wrapped bounds stay exact.
    at_lo  = c.lower_finite && (x - lo <= longint'(tol_q));
    at_up  = c.upper_finite && (up - x <= longint'(tol_q));
    zeroed = (at_lo && g > 0) || (at_up && g < 0);
    if (zeroed) pg = 0;
    else if (!c.gradient_finite) pg = Q_SAT;
    else pg = clip(magnitude(g));
    xs = magnitude(x);
    if (xs < Q_UNIT) xs = Q_UNIT;
    sg = q_mul(pg, xs);
    if (pg > pg_peak) pg_peak = pg;
    if (sg > scaled_peak) scaled_peak = sg;
    if (c.gradient_finite) begin
      if (clip(magnitude(g)) > raw_peak) raw_peak = clip(magnitude(g));
    end else begin
      grad_all_finite = 1'b0;
    end

    r = '0;
    r.active_code = at_up ? ACT_UPPER : (at_lo ? ACT_LOWER : ACT_INTERIOR);
    if (c.last_coord) begin
      r.final_flag     = 1'b1;
      r.projected_norm = 31'(pg_peak);
      r.raw_norm       = grad_all_finite ? 31'(raw_peak) : '0;
      r.raw_norm_valid = grad_all_finite;
      r.objective_ok   = c.objective_finite;
      if (c.objective_finite) begin
        obj_mag          = magnitude(f);
        den              = (obj_mag < Q_UNIT) ? Q_UNIT : obj_mag;
        r.scaled_norm    = 31'((scaled_peak << FRAC) / den);
        thr              = rel_mode_q ? q_mul(rel_thr_q, Q_UNIT + obj_mag) : abs_thr_q;
        r.threshold_used = 31'(thr);
        r.is_stationary  = (pg_peak <= thr);
        if (c.reported_finite) begin
          // Compare against the unsaturated tolerance band.
          allow           = (cons_rel_q * (Q_UNIT + magnitude(rep))) >> FRAC;
          r.is_consistent = (magnitude(f - rep) <= allow);
        end
      end
      pg_peak         = 0;
      scaled_peak     = 0;
      raw_peak        = 0;
      grad_all_finite = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  function automatic coord_t coord(
    input logic [31:0] x, input logic [31:0] g, input logic gf,
    input logic [31:0] lo, input logic lf, input logic [31:0] up, input logic uf,
    input logic last, input logic [31:0] f, input logic ff,
    input logic [31:0] rep, input logic rf
  );
    coord_t c;
    c.coord_value      = x;
    c.coord_gradient   = g;
    c.gradient_finite  = gf;
    c.lower_bound      = lo;
    c.lower_finite     = lf;
    c.upper_bound      = up;
    c.upper_finite     = uf;
    c.last_coord       = last;
    c.objective_value  = f;
    c.objective_finite = ff;
    c.reported_value   = rep;
    c.reported_finite  = rf;
    return c;
  endfunction

  function automatic result_t outcome(
    input act_code_e code, input logic fin, input logic [30:0] pn,
    input logic [30:0] rn, input logic rnv, input logic [30:0] sn,
    input logic [30:0] thr, input logic st, input logic cons, input logic ok
  );
    result_t r;
    r.active_code    = code;
    r.final_flag     = fin;
    r.projected_norm = pn;
    r.raw_norm       = rn;
    r.raw_norm_valid = rnv;
    r.scaled_norm    = sn;
    r.threshold_used = thr;
    r.is_stationary  = st;
    r.is_consistent  = cons;
    r.objective_ok   = ok;
    return r;
  endfunction

  function automatic void add_probe(input coord_t c, input bit typed, input result_t want);
    probe_row_t row;
    row.stim  = c;
    row.typed = typed;
    row.want  = want;
    probe_tab.insert(probe_tab.size(), row);
  endfunction

  // Bias toward the ends of the range and toward zero.
  function automatic logic [31:0] draw_word();
    case ($urandom_range(5))
      0:       return Q_MIN + $urandom_range(3);
      1:       return Q_MAX - $urandom_range(3);
      2:       return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  // Distance from a bound: tiny, right at the tolerance edge, or up to two units.
  function automatic logic [31:0] draw_offset();
    logic [31:0] d;
    case ($urandom_range(2))
      0:       d = $urandom_range(2);
      1:       d = 32'(tol_q) + $urandom_range(2) - 1;
      default: d = $urandom_range(32'h0002_0000);
    endcase
    return $urandom_range(1) ? d : -d;
  endfunction

  function automatic logic [30:0] draw_cfg();
    case ($urandom_range(3))
      0:       return '0;
      1:       return Q31_MAX;
      2:       return $urandom_range(32'h0004_0000);
      default: return 31'($urandom());
    endcase
  endfunction

  // Random coordinate, most of the time parked on or near one of its bounds.
  function automatic coord_t draw_coord(input bit closes);
    coord_t c;
    c.lower_bound = draw_word();
    c.upper_bound = ($urandom_range(3) == 0) ? c.lower_bound + draw_offset() : draw_word();
    case ($urandom_range(4))
      0, 1:    c.coord_value = c.lower_bound + draw_offset();
      2, 3:    c.coord_value = c.upper_bound - draw_offset();
      default: c.coord_value = draw_word();
    endcase
    c.coord_gradient   = draw_word();
    c.gradient_finite  = ($urandom_range(15) != 0);
    c.lower_finite     = ($urandom_range(7) != 0);
    c.upper_finite     = ($urandom_range(7) != 0);
    c.last_coord       = closes;
    c.objective_value  = draw_word();
    c.objective_finite = ($urandom_range(9) != 0);
    c.reported_value   = $urandom_range(1) ? c.objective_value + draw_offset() : draw_word();
    c.reported_finite  = ($urandom_range(9) != 0);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  task automatic put_coord(input coord_t c);
    coord_ch.coord_value      <= c.coord_value;
    coord_ch.coord_gradient   <= c.coord_gradient;
    coord_ch.gradient_finite  <= c.gradient_finite;
    coord_ch.lower_bound      <= c.lower_bound;
    coord_ch.lower_finite     <= c.lower_finite;
    coord_ch.upper_bound      <= c.upper_bound;
    coord_ch.upper_finite     <= c.upper_finite;
    coord_ch.last_coord       <= c.last_coord;
    coord_ch.objective_value  <= c.objective_value;
    coord_ch.objective_finite <= c.objective_finite;
    coord_ch.reported_value   <= c.reported_value;
    coord_ch.reported_finite  <= c.reported_finite;
  endtask

  // Offer one coordinate word after a random gap; on acceptance queue the
  // expected result (hand-typed if given, predicted otherwise).
  task automatic send_coord(input coord_t c, input bit typed, input result_t want);
    result_t r;
    while ($urandom_range(99) < idle_pct) begin
      coord_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    put_coord(c);
    coord_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!coord_ch.ready) @(posedge clk_i);
    // Advance the predictor even for typed rows so the point state stays in step.
    r = audit_coord(c);
    results_due.insert(results_due.size(), typed ? want : r);
  endtask

  // Drop valid and hold until every queued result has come back.
  task automatic drain();
    coord_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [30:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      CFG_BOUND_TOL: tol_q      = val;
      CFG_CONS_REL:  cons_rel_q = val;
      CFG_REL_MODE:  rel_mode_q = val[0];
      CFG_ABS_THR:   abs_thr_q  = val;
      CFG_REL_THR:   rel_thr_q  = val;
      default: ;
    endcase
  endtask

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: check every accepted word, pace ready
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int      hold_left;
    result_t want;
    hold_left       = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_ch.valid && result_ch.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result word with nothing pending", $time);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("active_code",    want.active_code,    result_ch.active_code);
          check_field("final_flag",     want.final_flag,     result_ch.final_flag);
          check_field("projected_norm", want.projected_norm, result_ch.projected_norm);
          check_field("raw_norm",       want.raw_norm,       result_ch.raw_norm);
          check_field("raw_norm_valid", want.raw_norm_valid, result_ch.raw_norm_valid);
          check_field("scaled_norm",    want.scaled_norm,    result_ch.scaled_norm);
          check_field("threshold_used", want.threshold_used, result_ch.threshold_used);
          check_field("is_stationary",  want.is_stationary,  result_ch.is_stationary);
          check_field("is_consistent",  want.is_consistent,  result_ch.is_consistent);
          check_field("objective_ok",   want.objective_ok,   result_ch.objective_ok);
        end
      end
      // Hold off for a long stretch on request so the block backs up and
      // stalls its input; otherwise idle at random.
      if (out_hold_req) begin
        out_hold_req = 1'b0;
        hold_left    = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, probe table, then phases of random points
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int phase, sent, len, k;

    // Drive every input to a known value from time zero.
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_BOUND_TOL;
    cfg_data       = '0;
    coord_ch.valid = 1'b0;
    put_coord('0);

    // Shadow state matches the block after reset.
    tol_q           = 0;
    cons_rel_q      = 66;
    rel_mode_q      = 1'b0;
    abs_thr_q       = 66;
    rel_thr_q       = 66;
    pg_peak         = 0;
    scaled_peak     = 0;
    raw_peak        = 0;
    grad_all_finite = 1'b1;

    // Probe table, reset configuration: tolerance 0, absolute threshold 66.
    // Interior, lower (outward gradient zeroed), upper, both bounds at once.
    add_probe(coord(32'h0, Q_ONE, 1, 32'hFFFF_0000, 1, Q_ONE, 1, 0, 0, 0, 0, 0),
              1, outcome(ACT_INTERIOR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_probe(coord(32'hFFFE_0000, Q_ONE, 1, 32'hFFFE_0000, 1, Q_MAX, 1, 0, 0, 0, 0, 0),
              1, outcome(ACT_LOWER, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_probe(coord(32'h0003_0000, 32'hFFFF_8000, 1, Q_MIN, 1, 32'h0003_0000, 1,
                    0, 0, 0, 0, 0),
              1, outcome(ACT_UPPER, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_probe(coord(32'h0, 32'h5, 1, 32'h0, 1, 32'h0, 1, 0, 0, 0, 0, 0),
              1, outcome(ACT_UPPER, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Close the point: every norm is 1.0, objective 1.0 agrees with itself.
    add_probe(coord(32'h0, 32'h0, 1, 0, 0, 0, 0, 1, Q_ONE, 1, Q_ONE, 1),
              1, outcome(ACT_INTERIOR, 1, 31'h1_0000, 31'h1_0000, 1, 31'h1_0000,
                         31'd66, 0, 1, 1));
    // Extremes: magnitude of the most negative word saturates.
    add_probe(coord(Q_MIN, Q_MIN, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
              1, outcome(ACT_INTERIOR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_probe(coord(Q_MAX, Q_MAX, 1, Q_MIN, 1, Q_MAX, 1, 0, 0, 0, 0, 0),
              1, outcome(ACT_UPPER, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Non-finite objective blanks the objective-dependent fields.
    add_probe(coord(32'h0, 32'h0, 1, 0, 0, 0, 0, 1, 32'h1234_5678, 0, 0, 1),
              1, outcome(ACT_INTERIOR, 1, Q31_MAX, Q31_MAX, 1, 0, 0, 0, 0, 0));
    // Non-finite gradient: once counted as infinity, once zeroed at a bound.
    add_probe(coord(32'h0, 32'hFFFF_FFFD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
              1, outcome(ACT_INTERIOR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_probe(coord(Q_ONE, 32'h7, 0, Q_ONE, 1, Q_MAX, 1, 0, 0, 0, 0, 0),
              1, outcome(ACT_LOWER, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Close with extreme objectives; raw norm is invalid for this point.
    add_probe(coord(32'h0, 32'h0, 1, 0, 0, 0, 0, 1, Q_MIN, 1, Q_MAX, 1), 0, '0);
    // One step past a zero tolerance, then non-finite bounds never active.
    add_probe(coord(32'h1, 32'h2, 1, 32'h0, 1, Q_MAX, 1, 0, 0, 0, 0, 0),
              1, outcome(ACT_INTERIOR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_probe(coord(Q_ONE, 32'hFFFF_FFFF, 1, Q_ONE, 0, Q_ONE, 0, 0, 0, 0, 0, 0),
              1, outcome(ACT_INTERIOR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Zero non-finite gradient at the lower bound counts as plus infinity.
    add_probe(coord(Q_ONE, 32'h0, 0, Q_ONE, 1, Q_MAX, 1, 0, 0, 0, 0, 0), 0, '0);
    // Reported objective non-finite.
    add_probe(coord(32'hFFF0_0000, 32'h100, 1, 0, 0, 0, 0, 1, 32'h0002_0000, 1, 0, 0),
              0, '0);
    // Flat point at zero objective: stationary and consistent.
    add_probe(coord(32'h0, 32'h0, 1, 0, 0, 0, 0, 1, 32'h0, 1, 32'h0, 1),
              1, outcome(ACT_INTERIOR, 1, 0, 0, 1, 0, 31'd66, 1, 1, 1));
    // Consistency band: well inside and just outside its edge.
    add_probe(coord(32'h0, 32'h0, 1, 0, 0, 0, 0, 1, Q_ONE + 66, 1, Q_ONE, 1), 0, '0);
    add_probe(coord(32'h0, 32'h0, 1, 0, 0, 0, 0, 1, Q_ONE + 133, 1, Q_ONE, 1), 0, '0);
    // Large objective drives the divider.
    add_probe(coord(32'h0004_0000, 32'h0002_0000, 1, 0, 0, 0, 0, 1,
                    32'hFFFD_0000, 1, 32'hFFFD_0000, 1), 0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probe_tab[i]) send_coord(probe_tab[i].stim, probe_tab[i].typed, probe_tab[i].want);

    for (phase = 0; phase < PHASES; phase++) begin
      // Reprogram only once the block has handed back every result.
      if (phase > 0) begin
        drain();
        case (phase)
          1: begin
            write_reg(CFG_BOUND_TOL, Q31_MAX);
            write_reg(CFG_CONS_REL,  Q31_MAX);
            write_reg(CFG_REL_MODE,  31'd1);
            write_reg(CFG_ABS_THR,   '0);
            write_reg(CFG_REL_THR,   Q31_MAX);
          end
          2: begin
            write_reg(CFG_BOUND_TOL, '0);
            write_reg(CFG_CONS_REL,  '0);
            write_reg(CFG_REL_MODE,  '0);
            write_reg(CFG_ABS_THR,   Q31_MAX);
            write_reg(CFG_REL_THR,   '0);
          end
          default: begin
            write_reg(CFG_BOUND_TOL, draw_cfg());
            write_reg(CFG_CONS_REL,  draw_cfg());
            write_reg(CFG_REL_MODE,  31'($urandom_range(1)));
            write_reg(CFG_ABS_THR,   draw_cfg());
            write_reg(CFG_REL_THR,   draw_cfg());
          end
        endcase
        cfg_we <= 1'b0;
      end
      // Run phase 3 back to back on both sides; the other phases idle at random.
      idle_pct = (phase == 3) ? 0 : 22;
      sent     = 0;
      while (sent < PHASE_LEN) begin
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++) begin
          send_coord(draw_coord(k == len - 1), 1'b0, '0);
          sent++;
          if (phase == 2 && sent == 30) out_hold_req = 1'b1;
          // Pause mid-point until the pipeline is empty.
          if (phase == 4 && sent == 100) drain();
        end
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/bbsa_pkg.sv
src/bbsa_if.sv
src/bbsa_div.sv
src/bbsa_dp.sv
src/bbsa_ctrl.sv
src/box_bound_stationarity_audit_unit.sv
src/bbsa_chk.sv
sim/box_bound_stationarity_audit_unit_tb.sv
